// ----- sv/etuc_pkg.sv -----
// package for the epoch seconds to utc calendar block
// constants, state type, month length table; no dependencies
`default_nettype none
package etuc_pkg;
    localparam int IN_W = 63;
    localparam int DAYS_W = 47;
    localparam int CYC_W = 30;
    localparam logic [30:0] YEAR_LIMIT = 31'h7FFFFFFF;

    // reciprocals floor(2^63 / d) for the constant divider
    localparam logic [62:0] MAG_60  = 63'(64'h8000_0000_0000_0000 / 64'd60);
    localparam logic [62:0] MAG_24  = 63'(64'h8000_0000_0000_0000 / 64'd24);
    localparam logic [62:0] MAG_7   = 63'(64'h8000_0000_0000_0000 / 64'd7);
    localparam logic [62:0] MAG_CYC = 63'(64'h8000_0000_0000_0000 / 64'd146097);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV60A, ST_DIV60B, ST_DIV24, ST_DIV7, ST_DIVCYC,
        ST_YEAR, ST_MONTH, ST_DONE
    } t_state;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] v;
        begin
            case (mon)
                4'd1: v = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10: v = 5'd30;
                default: v = 5'd31;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

// ----- sv/etuc_if.sv -----
// valid/ready channel interfaces for the block
// depends on nothing
`default_nettype none
interface etuc_in_if;
    logic        valid;
    logic        ready;
    logic [62:0] epoch_seconds;
    modport source (output valid, epoch_seconds, input ready);
    modport sink (input valid, epoch_seconds, output ready);
endinterface

interface etuc_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [30:0] years_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic        overflow;
    modport source (output valid, second, minute, hour, day_of_month, month,
        years_since_1900, weekday, day_of_year, overflow, input ready);
    modport sink (input valid, second, minute, hour, day_of_month, month,
        years_since_1900, weekday, day_of_year, overflow, output ready);
endinterface
`default_nettype wire

// ----- sv/etuc_cdiv.sv -----
// divider by a constant through reciprocal multiplication on one shared
// 32x32 multiplier; depends on nothing
`default_nettype none
module etuc_cdiv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [62:0] i_num,
    input  wire logic [17:0] i_den,
    input  wire logic [62:0] i_mag,
    output logic             o_busy,
    output logic [62:0]      o_quo,
    output logic [17:0]      o_rem
);
    logic [2:0]   r_step;
    logic         r_busy;
    logic [62:0]  r_n;
    logic [62:0]  r_m;
    logic [62:0]  r_q;
    logic [17:0]  r_d;
    logic [125:0] r_acc;
    logic [31:0]  r_r;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;

    // partial products of num * mag, then quotient estimate * den
    always_comb begin
        case (r_step)
            3'd0: begin
                mul_a = r_n[31:0];
                mul_b = r_m[31:0];
            end
            3'd1: begin
                mul_a = r_n[31:0];
                mul_b = {1'b0, r_m[62:32]};
            end
            3'd2: begin
                mul_a = {1'b0, r_n[62:32]};
                mul_b = r_m[31:0];
            end
            3'd3: begin
                mul_a = {1'b0, r_n[62:32]};
                mul_b = {1'b0, r_m[62:32]};
            end
            default: begin
                mul_a = r_acc[94:63];
                mul_b = {14'd0, r_d};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 3'd0;
        end else if (r_busy) begin
            if (r_step == 3'd5) r_busy <= 1'b0;
            r_step <= r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_num;
            r_m   <= i_mag;
            r_d   <= i_den;
            r_acc <= '0;
        end else if (r_busy) begin
            case (r_step)
                3'd0: r_acc <= r_acc + {62'd0, mul_p};
                3'd1, 3'd2: r_acc <= r_acc + {30'd0, mul_p, 32'd0};
                3'd3: r_acc <= r_acc + {mul_p[61:0], 64'd0};
                3'd4: begin
                    r_q <= r_acc[125:63];
                    r_r <= r_n[31:0] - mul_p[31:0];
                end
                // estimate is low by at most one
                3'd5: if (r_r >= {14'd0, r_d}) begin
                    r_q <= r_q + 63'd1;
                    r_r <= r_r - {14'd0, r_d};
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_busy = r_busy | i_start;
    assign o_quo  = r_q;
    assign o_rem  = r_r[17:0];
endmodule
`default_nettype wire

// ----- sv/epoch_seconds_to_utc_calendar_core.sv -----
// epoch seconds to utc calendar, top level
// uses etuc_pkg, etuc_if and etuc_cdiv
//
// usage: one beat on s_in (seconds since 1970) gives one beat on m_out with
// the broken-down utc time, or overflow set and all other fields zero.
// the block takes one beat at a time; s_in.ready is high only when idle.
// processing: five passes of the shared constant divider (by 60, 60, 24, 7
// and 146097), each with start and unload, then one year step per cycle
// (up to 399) and one month step per cycle (up to 11) before the result.
// the shared 32x32 multiplier and the year and month loops set the pace.
// a result holds on m_out until m_out.ready; no new beat is taken meanwhile.
// reset (synchronous, active low) returns to idle with no result pending.
`default_nettype none
module epoch_seconds_to_utc_calendar_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    etuc_in_if.sink   s_in,
    etuc_out_if.source m_out
);
    import etuc_pkg::*;

    t_state r_state, n_state;
    logic        div_start, div_busy;
    logic [62:0] div_num, div_quo;
    logic [62:0] div_mag;
    logic [17:0] div_den, div_rem;
    logic [62:0] r_val;
    logic [5:0]  r_sec, r_min;
    logic [4:0]  r_hour;
    logic [2:0]  r_wday;
    logic [46:0] r_days;
    logic [17:0] r_rem;
    logic [47:0] r_year;
    logic [3:0]  r_mon;
    logic [8:0]  r_doy;
    logic        r_started;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    etuc_cdiv u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .i_mag(div_mag), .o_busy(div_busy), .o_quo(div_quo),
        .o_rem(div_rem)
    );

    // year offset is 70 + 400k, so leap test works on (year+1900) mod 400
    // tracked separately as the year only steps by one
    logic [8:0] r_y400;
    assign leap = (r_y400 == 9'd0) ||
        ((r_y400 != 9'd100) && (r_y400 != 9'd200) && (r_y400 != 9'd300)
         && (r_y400[1:0] == 2'b00));
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(leap, r_mon);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_in.valid) n_state = ST_DIV60A;
            ST_DIV60A: if (r_started && !div_busy) n_state = ST_DIV60B;
            ST_DIV60B: if (r_started && !div_busy) n_state = ST_DIV24;
            ST_DIV24:  if (r_started && !div_busy) n_state = ST_DIV7;
            ST_DIV7:   if (r_started && !div_busy) n_state = ST_DIVCYC;
            ST_DIVCYC: if (r_started && !div_busy) n_state = ST_YEAR;
            ST_YEAR:   if ({9'd0, r_rem} < {18'd0, ylen}) n_state = ST_MONTH;
            ST_MONTH:  if (r_mon == 4'd11 || r_rem < {13'd0, mlen}) n_state = ST_DONE;
            ST_DONE:   if (m_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = r_val;
        div_den   = 18'd60;
        div_mag   = MAG_60;
        case (r_state)
            ST_DIV60A: begin div_start = !r_started; div_den = 18'd60; end
            ST_DIV60B: begin div_start = !r_started; div_den = 18'd60; end
            ST_DIV24: begin
                div_start = !r_started;
                div_den   = 18'd24;
                div_mag   = MAG_24;
            end
            ST_DIV7: begin
                div_start = !r_started;
                div_num   = {16'd0, r_days} + 63'd4;
                div_den   = 18'd7;
                div_mag   = MAG_7;
            end
            ST_DIVCYC: begin
                div_start = !r_started;
                div_num   = {16'd0, r_days};
                div_den   = 18'd146097;
                div_mag   = MAG_CYC;
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= (n_state == r_state) ? (r_started | div_start) : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (s_in.valid) r_val <= s_in.epoch_seconds;
            ST_DIV60A: if (r_started && !div_busy) begin
                r_sec <= div_rem[5:0]; r_val <= div_quo;
            end
            ST_DIV60B: if (r_started && !div_busy) begin
                r_min <= div_rem[5:0]; r_val <= div_quo;
            end
            ST_DIV24: if (r_started && !div_busy) begin
                r_hour <= div_rem[4:0]; r_days <= div_quo[46:0];
            end
            ST_DIV7: if (r_started && !div_busy) r_wday <= div_rem[2:0];
            ST_DIVCYC: if (r_started && !div_busy) begin
                r_rem  <= div_rem;
                r_year <= {div_quo[39:0], 8'd0} + {div_quo[40:0], 7'd0}
                          + {div_quo[43:0], 4'd0} + 48'd70;
                r_y400 <= 9'd370;
                r_mon  <= 4'd0;
                r_doy  <= 9'd0;
            end
            ST_YEAR: if ({9'd0, r_rem} >= {18'd0, ylen}) begin
                r_rem  <= r_rem - {9'd0, ylen};
                r_year <= r_year + 48'd1;
                r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
            end
            ST_MONTH: if (!(r_mon == 4'd11 || r_rem < {13'd0, mlen})) begin
                r_rem <= r_rem - {13'd0, mlen};
                r_doy <= r_doy + {4'd0, mlen};
                r_mon <= r_mon + 4'd1;
            end
            default: r_val <= r_val;
        endcase
    end

    logic ovf;
    assign ovf = (r_year > {17'd0, YEAR_LIMIT});
    assign s_in.ready = (r_state == ST_IDLE);
    assign m_out.valid = (r_state == ST_DONE);
    assign m_out.second = ovf ? 6'd0 : r_sec;
    assign m_out.minute = ovf ? 6'd0 : r_min;
    assign m_out.hour = ovf ? 5'd0 : r_hour;
    assign m_out.day_of_month = ovf ? 5'd0 : (r_rem[4:0] + 5'd1);
    assign m_out.month = ovf ? 4'd0 : r_mon;
    assign m_out.years_since_1900 = ovf ? 31'd0 : r_year[30:0];
    assign m_out.weekday = ovf ? 3'd0 : r_wday;
    assign m_out.day_of_year = ovf ? 9'd0 : (r_doy + r_rem[8:0]);
    assign m_out.overflow = ovf;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready) |=> !s_in.ready)
        else $error("accepted a beat while busy");
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_in.ready && m_out.valid))
        else $error("input ready with result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(m_out.month)))
        else $error("result dropped under stall");
`endif
endmodule
`default_nettype wire

// ----- tb/etuc_tb_if.sv -----
// testbench package: expected-result predictor and scoreboard for the core
// depends on etuc_pkg
`timescale 1ns / 100ps
package etuc_tb_pkg;
    import etuc_pkg::*;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [30:0] years_since_1900;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
        logic        overflow;
    } t_utc_time;

    function automatic bit is_leap_year(longint unsigned ofs1900);
        longint unsigned y;
        y = ofs1900 + 1900;
        if (y % 400 == 0) return 1;
        if (y % 100 == 0) return 0;
        return (y % 4 == 0);
    endfunction

    function automatic t_utc_time calendar_of(logic [62:0] secs);
        longint unsigned t, days, rem, year;
        int unsigned mon, mlen, doy;
        bit leap;
        t_utc_time r;
        r = '0;
        t = {1'b0, secs};
        r.second = 6'(t % 60);
        t = t / 60;
        r.minute = 6'(t % 60);
        t = t / 60;
        r.hour = 5'(t % 24);
        days = t / 24;
        r.weekday = 3'((days + 4) % 7);
        year = 70 + (days / 146097) * 400;
        rem = days % 146097;
        leap = is_leap_year(year);
        while (rem >= 365 + leap) begin
            rem -= 365 + leap;
            year++;
            leap = is_leap_year(year);
        end
        mon = 0;
        doy = 0;
        while (mon < 11) begin
            mlen = (mon == 1) ? (leap ? 29 : 28) :
                   (mon == 3 || mon == 5 || mon == 8 || mon == 10) ? 30 : 31;
            if (rem < mlen) break;
            rem -= mlen;
            doy += mlen;
            mon++;
        end
        if (year > 64'd2147483647) begin
            r = '0;
            r.overflow = 1'b1;
            return r;
        end
        r.day_of_month = 5'(rem + 1);
        r.month = 4'(mon);
        r.years_since_1900 = 31'(year);
        r.day_of_year = 9'(doy + rem);
        return r;
    endfunction

    class utc_scoreboard;
        t_utc_time pending[$];
        int errors;

        function void note_seconds(logic [62:0] secs);
            pending.push_back(calendar_of(secs));
        endfunction

        function void check_time(t_utc_time got);
            t_utc_time exp;
            if (pending.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.second !== exp.second) begin
                $error("second exp %0d got %0d", exp.second, got.second); errors++;
            end
            if (got.minute !== exp.minute) begin
                $error("minute exp %0d got %0d", exp.minute, got.minute); errors++;
            end
            if (got.hour !== exp.hour) begin
                $error("hour exp %0d got %0d", exp.hour, got.hour); errors++;
            end
            if (got.day_of_month !== exp.day_of_month) begin
                $error("day_of_month exp %0d got %0d", exp.day_of_month, got.day_of_month);
                errors++;
            end
            if (got.month !== exp.month) begin
                $error("month exp %0d got %0d", exp.month, got.month); errors++;
            end
            if (got.years_since_1900 !== exp.years_since_1900) begin
                $error("years_since_1900 exp %0d got %0d", exp.years_since_1900,
                    got.years_since_1900);
                errors++;
            end
            if (got.weekday !== exp.weekday) begin
                $error("weekday exp %0d got %0d", exp.weekday, got.weekday); errors++;
            end
            if (got.day_of_year !== exp.day_of_year) begin
                $error("day_of_year exp %0d got %0d", exp.day_of_year, got.day_of_year);
                errors++;
            end
            if (got.overflow !== exp.overflow) begin
                $error("overflow exp %0d got %0d", exp.overflow, got.overflow); errors++;
            end
        endfunction
    endclass
endpackage

// ----- tb/testbench.sv -----
// top-level testbench for epoch_seconds_to_utc_calendar_core
// drives directed and random epoch times, checks against etuc_tb_pkg predictor
`timescale 1ns / 100ps
module testbench;
    import etuc_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    etuc_in_if  s_in();
    etuc_out_if m_out();
    utc_scoreboard board;
    int send_idle_pct = 14;
    int recv_idle_pct = 50;
    bit sending_done = 0;

    epoch_seconds_to_utc_calendar_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in.sink), .m_out(m_out.source)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        s_in.valid = 1'b0;
        s_in.epoch_seconds = '0;
        m_out.ready = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the accept
    task automatic send_seconds(logic [62:0] secs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.epoch_seconds <= secs;
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        board.note_seconds(secs);
        @(negedge i_clk);
    endtask

    function automatic logic [62:0] random_seconds();
        logic [62:0] v;
        int kind;
        kind = $urandom_range(9);
        v = 63'({$urandom, $urandom});
        case (kind)
            0, 1, 2: v = v % 63'd4102444800;
            3, 4: v = v % 63'd253402300800;
            5: v = v % 63'd67767976233316800;
            6: v = 63'd67767976233432799 + 63'($urandom_range(200000));
            7: v = 63'd951782400 + $urandom_range(200) * 63'd86400 / 2
                   + $urandom_range(86399);
            default: ;
        endcase
        return v;
    endfunction

    // receiver: random stalls, sample at rising edge
    always @(negedge i_clk) begin
        m_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_utc_time got;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            got.second = m_out.second;
            got.minute = m_out.minute;
            got.hour = m_out.hour;
            got.day_of_month = m_out.day_of_month;
            got.month = m_out.month;
            got.years_since_1900 = m_out.years_since_1900;
            got.weekday = m_out.weekday;
            got.day_of_year = m_out.day_of_year;
            got.overflow = m_out.overflow;
            board.check_time(got);
        end
    end

    initial begin
        logic [62:0] directed[$];
        int n;
        board = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed = '{63'd0, 63'd59, 63'd3599, 63'd86399, 63'd86400,
            63'd951782400, 63'd951868800, 63'd978220800, 63'd1078012800,
            63'd2147483647, 63'd2147483648, 63'd4107542400, 63'd13574563200,
            63'd946684799, 63'd1234567890, 63'd12622780800,
            63'd67767976233316799, 63'd67767976233532799,
            63'd67767976233532800, 63'd67768036191676799,
            63'd67768036191676800, 63'h7FFF_FFFF_FFFF_FFFF,
            63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA};
        foreach (directed[i]) send_seconds(directed[i]);
        for (n = 0; n < 700; n++) begin
            if (n == 233) begin
                send_idle_pct = 50;
                recv_idle_pct = 14;
            end else if (n == 466) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_seconds(random_seconds());
        end
        s_in.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("epoch_seconds_to_utc_calendar_core regression: pass");
        else
            $display("epoch_seconds_to_utc_calendar_core regression: fail");
        $finish;
    end

    initial begin
        #40ms;
        $display("epoch_seconds_to_utc_calendar_core regression: fail");
        $finish;
    end
endmodule
